// File: hdl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
// No dependencies; imported by the ALU and top level.
`default_nettype none

package ffba_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } ffba_opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_REUSED  = 3'd1,
    ST_ZERO    = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_FULL    = 3'd4,
    ST_NULL    = 3'd5,
    ST_DOUBLE  = 3'd6,
    ST_UNKNOWN = 3'd7
  } ffba_status_e;

  typedef enum logic {
    CFG_HEAP_START = 1'b0,
    CFG_HEAP_END   = 1'b1
  } ffba_cfg_idx_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } ffba_alu_op_e;

  // 33-bit datapath: totals may exceed 32 bits before the limit check
  localparam int unsigned ALU_W = 33;

  typedef struct packed {
    ffba_alu_op_e     op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } ffba_alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             ge;   // a >= b, valid for ALU_SUB
    logic             eq;   // a == b, valid for ALU_SUB
  } ffba_alu_rsp_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] req_size;
    logic [31:0] user_address;
  } ffba_req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [31:0] granted_size;
    logic [2:0]  status;
  } ffba_rsp_t;

endpackage

`default_nettype wire

// File: hdl/ffba_stream_if.sv
// Valid/ready stream interface, payload type set per instance.
// Used for the request and response channels of the allocator.
`default_nettype none

interface ffba_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ffba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ffba_alu.sv
// Shared 33-bit add/subtract-compare unit of the allocator sequencer.
// Depends on ffba_pkg.
`default_nettype none

module ffba_alu (
  input  ffba_pkg::ffba_alu_req_t req_i,
  output ffba_pkg::ffba_alu_rsp_t rsp_o
);
  import ffba_pkg::*;

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   full;

  always_comb begin
    b_eff = (req_i.op == ALU_SUB) ? ~req_i.b : req_i.b;
    full  = {1'b0, req_i.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, (req_i.op == ALU_SUB)};
    rsp_o.res = full[ALU_W-1:0];
    rsp_o.ge  = full[ALU_W];          // carry out means no borrow
    rsp_o.eq  = (full[ALU_W-1:0] == '0);
  end

endmodule

`default_nettype wire

// File: hdl/first_fit_block_allocator.sv
// Operation: alloc walks the free list from its front and, when a reused block
//   leaves the list, moves the entries behind it down; free scans the block
//   table. Throughput: one request at a time, next beat taken the cycle after
//   the result loads; a result not taken holds the next one off.
// Reset: async active low; clears counts, in-use bits, bump pointer, config.
//   RAM contents are not cleared (entries are written before they are read).
`default_nettype none

module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ffba_stream_if.sink      req_i,
  ffba_stream_if.source    rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import ffba_pkg::*;

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_ROOM   = 15'h0002,
    S_LIMIT  = 15'h0004,
    S_ORD_RD = 15'h0008,
    S_BYT_RD = 15'h0010,
    S_CMP    = 15'h0020,
    S_START  = 15'h0040,
    S_SH_RD  = 15'h0080,
    S_SH_WR  = 15'h0100,
    S_NEW    = 15'h0200,
    S_BUMP   = 15'h0400,
    S_LK_RD  = 15'h0800,
    S_LK_CMP = 15'h1000,
    S_FR_BYT = 15'h2000,
    S_DONE   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]           heap_start_q, heap_end_q;
  logic [31:0]           bump_q, bump_d;
  logic [CW-1:0]         bc_q, bc_d, fc_q, fc_d;
  logic [MAX_BLOCKS-1:0] in_use_q, in_use_d;
  logic                  rsp_valid_q, rsp_valid_d;

  logic [ALU_W-1:0] total_q, total_d, room_q, room_d;
  logic [31:0]      base_q, base_d, bytes_q, bytes_d;
  logic [IW-1:0]    s_q, s_d, i_q, i_d, idx_q, idx_d;
  logic [31:0]      res_addr_q, res_addr_d, res_bytes_q, res_bytes_d;
  ffba_status_e     res_st_q, res_st_d;
  ffba_rsp_t        rsp_q, rsp_d;

  ffba_alu_req_t alu_req;
  ffba_alu_rsp_t alu_rsp;

  logic             start_rd_en, bytes_rd_en, order_rd_en;
  logic [IW-1:0]    start_rd_addr, bytes_rd_addr, order_rd_addr;
  logic [31:0]      start_rd_data, bytes_rd_data;
  logic [IW-1:0]    order_rd_data;
  logic             blk_wr_en, order_wr_en;
  logic [IW-1:0]    order_wr_addr, order_wr_data;

  logic [CW-1:0] fc_m1;
  logic [IW-1:0] s_p1;

  ffba_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ffba_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_start_ram (
    .clk_i     (clk_i),
    .wr_en_i   (blk_wr_en),
    .wr_addr_i (bc_q[IW-1:0]),
    .wr_data_i (bump_q),
    .rd_en_i   (start_rd_en),
    .rd_addr_i (start_rd_addr),
    .rd_data_o (start_rd_data)
  );

  ffba_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_bytes_ram (
    .clk_i     (clk_i),
    .wr_en_i   (blk_wr_en),
    .wr_addr_i (bc_q[IW-1:0]),
    .wr_data_i (total_q[31:0]),
    .rd_en_i   (bytes_rd_en),
    .rd_addr_i (bytes_rd_addr),
    .rd_data_o (bytes_rd_data)
  );

  // Free list stored oldest first: slot fc-1 is the list front.
  ffba_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_order_ram (
    .clk_i     (clk_i),
    .wr_en_i   (order_wr_en),
    .wr_addr_i (order_wr_addr),
    .wr_data_i (order_wr_data),
    .rd_en_i   (order_rd_en),
    .rd_addr_i (order_rd_addr),
    .rd_data_o (order_rd_data)
  );

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  assign fc_m1 = fc_q - CW'(1);
  assign s_p1  = s_q + IW'(1);

  always_comb begin
    state_d     = state_q;
    bump_d      = bump_q;
    bc_d        = bc_q;
    fc_d        = fc_q;
    in_use_d    = in_use_q;
    rsp_valid_d = rsp_valid_q;
    total_d     = total_q;
    room_d      = room_q;
    base_d      = base_q;
    bytes_d     = bytes_q;
    s_d         = s_q;
    i_d         = i_q;
    idx_d       = idx_q;
    res_addr_d  = res_addr_q;
    res_bytes_d = res_bytes_q;
    res_st_d    = res_st_q;
    rsp_d       = rsp_q;

    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;

    start_rd_en   = 1'b0;
    start_rd_addr = i_q;
    bytes_rd_en   = 1'b0;
    bytes_rd_addr = i_q;
    order_rd_en   = 1'b0;
    order_rd_addr = s_q;
    blk_wr_en     = 1'b0;
    order_wr_en   = 1'b0;
    order_wr_addr = s_q;
    order_wr_data = order_rd_data;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        res_addr_d  = '0;
        res_bytes_d = '0;
        res_st_d    = ST_OK;
        case (req_i.payload.opcode)
          OP_ALLOC: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {1'b0, req_i.payload.req_size};
            alu_req.b  = ALU_W'(HEADER_BYTES + 7);
          end
          OP_FREE: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, req_i.payload.user_address};
            alu_req.b  = ALU_W'(HEADER_BYTES);
          end
          OP_INIT: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {1'b0, heap_start_q};
            alu_req.b  = ALU_W'(7);
          end
          default: ;
        endcase
        if (req_i.valid) begin
          state_d = S_DONE;
          case (req_i.payload.opcode)
            OP_ALLOC: begin
              total_d = {alu_rsp.res[ALU_W-1:3], 3'b000};
              if (req_i.payload.req_size == '0) begin
                res_st_d = ST_ZERO;
              end else begin
                state_d = S_ROOM;
              end
            end
            OP_FREE: begin
              base_d = alu_rsp.res[31:0];
              i_d    = '0;
              if (req_i.payload.user_address == '0) begin
                res_st_d = ST_NULL;
              end else if (bc_q == '0) begin
                res_st_d = ST_UNKNOWN;
              end else begin
                state_d = S_LK_RD;
              end
            end
            OP_INIT: begin
              bump_d   = {alu_rsp.res[31:3], 3'b000};
              bc_d     = '0;
              fc_d     = '0;
              in_use_d = '0;
            end
            default: ;
          endcase
        end
      end

      S_ROOM: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, heap_end_q};
        alu_req.b  = {1'b0, bump_q};
        room_d     = alu_rsp.ge ? alu_rsp.res : '0;
        state_d    = S_LIMIT;
      end

      S_LIMIT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = room_q;
        alu_req.b  = total_q;
        s_d        = fc_m1[IW-1:0];
        if (!alu_rsp.ge) begin
          res_st_d = ST_LIMIT;
          state_d  = S_DONE;
        end else if (fc_q == '0) begin
          state_d = S_NEW;
        end else begin
          state_d = S_ORD_RD;
        end
      end

      S_ORD_RD: begin
        order_rd_en   = 1'b1;
        order_rd_addr = s_q;
        state_d       = S_BYT_RD;
      end

      S_BYT_RD: begin
        idx_d         = order_rd_data;
        bytes_rd_en   = 1'b1;
        bytes_rd_addr = order_rd_data;
        state_d       = S_CMP;
      end

      S_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, bytes_rd_data};
        alu_req.b  = total_q;
        if (alu_rsp.ge) begin
          bytes_d       = bytes_rd_data;
          start_rd_en   = 1'b1;
          start_rd_addr = idx_q;
          state_d       = S_START;
        end else if (s_q == '0) begin
          state_d = S_NEW;
        end else begin
          s_d     = s_q - IW'(1);
          state_d = S_ORD_RD;
        end
      end

      S_START: begin
        alu_req.op        = ALU_ADD;
        alu_req.a         = {1'b0, start_rd_data};
        alu_req.b         = ALU_W'(HEADER_BYTES);
        res_addr_d        = alu_rsp.res[31:0];
        res_bytes_d       = bytes_q;
        res_st_d          = ST_REUSED;
        in_use_d[idx_q]   = 1'b1;
        fc_d              = fc_m1;
        state_d           = S_SH_RD;
      end

      // close the gap left by the reused entry, one slot per pass
      S_SH_RD: begin
        if (CW'(s_q) >= fc_q) begin
          state_d = S_DONE;
        end else begin
          order_rd_en   = 1'b1;
          order_rd_addr = s_p1;
          state_d       = S_SH_WR;
        end
      end

      S_SH_WR: begin
        order_wr_en   = 1'b1;
        order_wr_addr = s_q;
        order_wr_data = order_rd_data;
        s_d           = s_p1;
        state_d       = S_SH_RD;
      end

      S_NEW: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, bump_q};
        alu_req.b  = ALU_W'(HEADER_BYTES);
        if (bc_q == CW'(MAX_BLOCKS)) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          blk_wr_en                   = 1'b1;
          in_use_d[bc_q[IW-1:0]]      = 1'b1;
          res_addr_d                  = alu_rsp.res[31:0];
          res_bytes_d                 = total_q[31:0];
          res_st_d                    = ST_OK;
          state_d                     = S_BUMP;
        end
      end

      S_BUMP: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, bump_q};
        alu_req.b  = total_q;
        bump_d     = alu_rsp.res[31:0];
        bc_d       = bc_q + CW'(1);
        state_d    = S_DONE;
      end

      S_LK_RD: begin
        start_rd_en   = 1'b1;
        start_rd_addr = i_q;
        state_d       = S_LK_CMP;
      end

      S_LK_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, start_rd_data};
        alu_req.b  = {1'b0, base_q};
        if (alu_rsp.eq) begin
          if (!in_use_q[i_q] || (fc_q == CW'(MAX_BLOCKS))) begin
            res_st_d = ST_DOUBLE;
            state_d  = S_DONE;
          end else begin
            in_use_d[i_q] = 1'b0;
            order_wr_en   = 1'b1;
            order_wr_addr = fc_q[IW-1:0];
            order_wr_data = i_q;
            fc_d          = fc_q + CW'(1);
            bytes_rd_en   = 1'b1;
            bytes_rd_addr = i_q;
            state_d       = S_FR_BYT;
          end
        end else if ((CW'(i_q) + CW'(1)) == bc_q) begin
          res_st_d = ST_UNKNOWN;
          state_d  = S_DONE;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = S_LK_RD;
        end
      end

      S_FR_BYT: begin
        res_bytes_d = bytes_rd_data;
        res_st_d    = ST_OK;
        state_d     = S_DONE;
      end

      // hold here until the output register is free
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d.result_address = res_addr_q;
          rsp_d.granted_size   = res_bytes_q;
          rsp_d.status         = res_st_q;
          rsp_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bump_q       <= '0;
      bc_q         <= '0;
      fc_q         <= '0;
      in_use_q     <= '0;
      rsp_valid_q  <= 1'b0;
      heap_start_q <= '0;
      heap_end_q   <= '0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      bc_q        <= bc_d;
      fc_q        <= fc_d;
      in_use_q    <= in_use_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEAP_START: heap_start_q <= cfg_wdata_i;
          CFG_HEAP_END:   heap_end_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q     <= total_d;
    room_q      <= room_d;
    base_q      <= base_d;
    bytes_q     <= bytes_d;
    s_q         <= s_d;
    i_q         <= i_d;
    idx_q       <= idx_d;
    res_addr_q  <= res_addr_d;
    res_bytes_q <= res_bytes_d;
    res_st_q    <= res_st_d;
    rsp_q       <= rsp_d;
  end

endmodule

`default_nettype wire
